[sv/quadrature_decoder_speed_meter_defines.svh]
// ---------------------------------------------------------------------------
// quadrature decoder speed meter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_DECODER_SPEED_METER_DEFINES_SVH
`define QUADRATURE_DECODER_SPEED_METER_DEFINES_SVH

// same-cycle implication
`define QDSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QDSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/qdsm_pkg.sv]
// ---------------------------------------------------------------------------
// qdsm_pkg
// shared constants, register codes and control structs of the speed meter
// ---------------------------------------------------------------------------
package qdsm_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIVISOR_BITS   = 16;

    localparam int STEPS_BITS = 16;
    localparam int SPS_BITS   = 26;
    localparam int RPM_BITS   = 30;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROUND    = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] INTERVAL_RESET = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] ROUND_RESET    = 16'd80;

    typedef struct packed {
        logic accept;
        logic start_div1;
        logic start_div2;
        logic grab_sps;
        logic grab_rpm;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
    } dp_status_t;

endpackage

[sv/qdsm_div.sv]
// ---------------------------------------------------------------------------
// qdsm_div
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`include "quadrature_decoder_speed_meter_defines.svh"

module qdsm_div #(
    parameter int DIVIDEND_BITS = qdsm_pkg::COUNT_BITS_DEF + 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [DIVIDEND_BITS-1:0]             dividend,
    input  logic [qdsm_pkg::DIVISOR_BITS-1:0]    divisor,
    output logic [DIVIDEND_BITS-1:0]             quotient,
    output logic                                 done
);

    localparam int DB    = qdsm_pkg::DIVISOR_BITS;
    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [DB-1:0]            rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DB-1:0]            divisor_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DB:0] shifted;
    logic [DB:0] trial;
    logic        fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        trial   = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DB-1:0] : shifted[DB-1:0];
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `QDSM_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider started while busy")
    `QDSM_ASSERT_NOW(a_done_idle, done_reg, !busy_reg && cnt_reg == '0, "done while busy")

endmodule

[sv/qdsm_datapath.sv]
// ---------------------------------------------------------------------------
// qdsm_datapath
// step decoding, window counters, config registers, scaling and results
// ---------------------------------------------------------------------------
`include "quadrature_decoder_speed_meter_defines.svh"

module qdsm_datapath #(
    parameter int COUNT_BITS = qdsm_pkg::COUNT_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  qdsm_pkg::ctrl_cmd_t                         cmd,
    output qdsm_pkg::dp_status_t                        status,
    input  logic                                        level_a,
    input  logic                                        level_b,
    input  logic                                        ms_tick,
    input  logic                                        cfg_write,
    input  logic [qdsm_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [qdsm_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    output logic signed [qdsm_pkg::STEPS_BITS-1:0]      window_steps,
    output logic signed [qdsm_pkg::SPS_BITS-1:0]        steps_per_second,
    output logic signed [qdsm_pkg::RPM_BITS-1:0]        revs_per_minute
);

    localparam int DW        = COUNT_BITS + 16;
    localparam int FULL_BITS = (DW + 1 > qdsm_pkg::RPM_BITS) ? DW + 1 : qdsm_pkg::RPM_BITS;
    localparam int CB        = qdsm_pkg::CFG_DATA_BITS;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    function automatic logic signed [COUNT_BITS-1:0] sat_step(
        input logic signed [COUNT_BITS-1:0] v,
        input logic                         up
    );
        logic signed [COUNT_BITS-1:0] r;
        r = v;
        if (up)
        begin
            if (v != CNT_MAX)
                r = v + 1'b1;
        end
        else
        begin
            if (v != CNT_MIN)
                r = v - 1'b1;
        end
        return r;
    endfunction

    logic [CB-1:0]                interval_reg;
    logic [CB-1:0]                round_reg;
    logic                         stored_a_reg;
    logic                         stored_b_reg;
    logic signed [COUNT_BITS-1:0] step_count_reg;
    logic [15:0]                  tick_count_reg;
    logic signed [COUNT_BITS-1:0] steps_reg;
    logic [DW-1:0]                q1_reg;
    logic [DW-1:0]                q2_reg;
    logic signed [qdsm_pkg::STEPS_BITS-1:0] window_steps_reg;
    logic signed [qdsm_pkg::SPS_BITS-1:0]   sps_reg;
    logic signed [qdsm_pkg::RPM_BITS-1:0]   rpm_reg;

    logic signed [COUNT_BITS-1:0] cnt_a;
    logic signed [COUNT_BITS-1:0] cnt_b;
    logic [CB-1:0]                win;
    logic [CB-1:0]                div2;
    logic [15:0]                  tick_next;
    logic                         close;

    logic                         neg;
    logic [COUNT_BITS-1:0]        steps_mag;
    logic [DW-1:0]                m_ext;
    logic [DW-1:0]                mag1000;
    logic [DW-1:0]                mag60;
    logic [DW-1:0]                div_dividend;
    logic [CB-1:0]                div_divisor;
    logic [DW-1:0]                div_quotient;
    logic                         div_done;

    logic signed [FULL_BITS-1:0]  steps_full;
    logic [FULL_BITS-1:0]         q1_ext;
    logic [FULL_BITS-1:0]         q2_ext;
    logic [FULL_BITS-1:0]         sps_full;
    logic [FULL_BITS-1:0]         rpm_full;

    // step decode, a before b
    always_comb
    begin
        cnt_a = (level_a != stored_a_reg) ? sat_step(step_count_reg, stored_b_reg != stored_a_reg)
                                          : step_count_reg;
        cnt_b = (level_b != stored_b_reg) ? sat_step(cnt_a, level_b != level_a) : cnt_a;
        win       = (interval_reg == '0) ? CB'(1) : interval_reg;
        div2      = (round_reg == '0) ? CB'(1) : round_reg;
        tick_next = tick_count_reg + 16'd1;
        close     = ms_tick && (tick_next >= win);
    end

    // scaling into divider operands
    always_comb
    begin
        neg          = steps_reg[COUNT_BITS-1];
        steps_mag    = neg ? (-steps_reg) : steps_reg;
        m_ext        = DW'(steps_mag);
        mag1000      = (m_ext << 10) - (m_ext << 4) - (m_ext << 3);
        mag60        = (q1_reg << 6) - (q1_reg << 2);
        div_dividend = cmd.start_div1 ? mag1000 : mag60;
        div_divisor  = cmd.start_div1 ? win : div2;
    end

    qdsm_div #(
        .DIVIDEND_BITS (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div1 || cmd.start_div2),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb
    begin
        steps_full = FULL_BITS'(steps_reg);
        q1_ext     = FULL_BITS'(q1_reg);
        q2_ext     = FULL_BITS'(q2_reg);
        sps_full   = neg ? (-q1_ext) : q1_ext;
        rpm_full   = neg ? (-q2_ext) : q2_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= qdsm_pkg::INTERVAL_RESET;
            round_reg      <= qdsm_pkg::ROUND_RESET;
            stored_a_reg   <= 1'b0;
            stored_b_reg   <= 1'b0;
            step_count_reg <= '0;
            tick_count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    qdsm_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                    qdsm_pkg::CFG_ROUND:    round_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                stored_a_reg <= level_a;
                stored_b_reg <= level_b;
                if (close)
                begin
                    step_count_reg <= '0;
                    tick_count_reg <= '0;
                end
                else
                begin
                    step_count_reg <= cnt_b;
                    if (ms_tick)
                        tick_count_reg <= tick_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && close)
            steps_reg <= cnt_b;
        if (cmd.grab_sps)
            q1_reg <= div_quotient;
        if (cmd.grab_rpm)
            q2_reg <= div_quotient;
        if (cmd.load_out)
        begin
            window_steps_reg <= steps_full[qdsm_pkg::STEPS_BITS-1:0];
            sps_reg          <= sps_full[qdsm_pkg::SPS_BITS-1:0];
            rpm_reg          <= rpm_full[qdsm_pkg::RPM_BITS-1:0];
        end
    end

    assign status.close    = close;
    assign status.div_done = div_done;

    assign window_steps     = window_steps_reg;
    assign steps_per_second = sps_reg;
    assign revs_per_minute  = rpm_reg;

    `QDSM_ASSERT_NEXT(a_window_clear, cmd.accept && close,
        step_count_reg == '0 && tick_count_reg == '0, "window not cleared at close")
    `QDSM_ASSERT_NOW(a_grab_on_done, cmd.grab_sps || cmd.grab_rpm, div_done,
        "quotient taken before divider done")

endmodule

[sv/qdsm_ctrl.sv]
// ---------------------------------------------------------------------------
// qdsm_ctrl
// sequencer for sample intake, the two divisions and result handoff
// ---------------------------------------------------------------------------
`include "quadrature_decoder_speed_meter_defines.svh"

module qdsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  qdsm_pkg::dp_status_t status,
    output qdsm_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    always_comb
    begin
        can_load       = !out_valid_reg || !out_stall;
        cmd.accept     = in_valid && (state_reg == ST_IDLE);
        cmd.start_div1 = (state_reg == ST_START1);
        cmd.start_div2 = (state_reg == ST_START2);
        cmd.grab_sps   = (state_reg == ST_WAIT1) && status.div_done;
        cmd.grab_rpm   = (state_reg == ST_WAIT2) && status.div_done;
        cmd.load_out   = (state_reg == ST_PUBLISH) && can_load;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid && status.close) state_next = ST_START1;
            ST_START1:  state_next = ST_WAIT1;
            ST_WAIT1:   if (status.div_done) state_next = ST_START2;
            ST_START2:  state_next = ST_WAIT2;
            ST_WAIT2:   if (status.div_done) state_next = ST_PUBLISH;
            ST_PUBLISH: if (can_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `QDSM_ASSERT_NOW(a_done_in_wait, status.div_done,
        state_reg == ST_WAIT1 || state_reg == ST_WAIT2, "divider done outside wait")
    `QDSM_ASSERT_NOW(a_word_from_publish, $rose(out_valid_reg),
        $past(state_reg == ST_PUBLISH), "result word without publish")

endmodule

[sv/quadrature_decoder_speed_meter.sv]
// ---------------------------------------------------------------------------
// quadrature_decoder_speed_meter
// x4 quadrature decoder with windowed steps, steps per second and rpm
// ---------------------------------------------------------------------------
// A sample word is taken at once while the sequencer is idle. A sample that
// closes the measurement window holds the input while the shared
// one-bit-per-cycle divider runs once for steps per second and once for rpm,
// plus any time the previous result word waits on out_stall. Config writes
// are always ready.
module quadrature_decoder_speed_meter #(
    parameter int COUNT_BITS = qdsm_pkg::COUNT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   level_a,
    input  logic                                   level_b,
    input  logic                                   ms_tick,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [qdsm_pkg::STEPS_BITS-1:0] window_steps,
    output logic signed [qdsm_pkg::SPS_BITS-1:0]   steps_per_second,
    output logic signed [qdsm_pkg::RPM_BITS-1:0]   revs_per_minute,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qdsm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [qdsm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    qdsm_pkg::ctrl_cmd_t  cmd;
    qdsm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    qdsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    qdsm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .level_a          (level_a),
        .level_b          (level_b),
        .ms_tick          (ms_tick),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .window_steps     (window_steps),
        .steps_per_second (steps_per_second),
        .revs_per_minute  (revs_per_minute)
    );

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// quadrature decoder speed meter testbench
// drives encoder sample words and register writes with random idle and
// stall bursts, predicts every window result and checks each result word
// ---------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SATURATE_WORDS = 12;

    typedef enum logic [1:0] {
        ACT_SAMPLE,
        ACT_WRITE,
        ACT_DRAIN
    } enc_action_kind_t;

    typedef struct {
        enc_action_kind_t                     kind;
        logic                                 a;
        logic                                 b;
        logic                                 tick;
        logic [qdsm_pkg::CFG_INDEX_BITS-1:0]  index;
        logic [qdsm_pkg::CFG_DATA_BITS-1:0]   data;
    } enc_action_t;

    typedef struct packed {
        logic signed [qdsm_pkg::STEPS_BITS-1:0] steps;
        logic signed [qdsm_pkg::SPS_BITS-1:0]   sps;
        logic signed [qdsm_pkg::RPM_BITS-1:0]   rpm;
    } speed_word_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic                                   level_a = 1'b0;
    logic                                   level_b = 1'b0;
    logic                                   ms_tick = 1'b0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [qdsm_pkg::STEPS_BITS-1:0] window_steps;
    logic signed [qdsm_pkg::SPS_BITS-1:0]   steps_per_second;
    logic signed [qdsm_pkg::RPM_BITS-1:0]   revs_per_minute;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [qdsm_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [qdsm_pkg::CFG_DATA_BITS-1:0]     cfg_data = '0;

    enc_action_t                            pending_actions[$];
    speed_word_t                            expected_speeds[$];
    int                                     speeds_owed = 0;
    logic                                   quiet = 1'b0;
    int                                     mismatches = 0;

    // generator view of the encoder levels
    logic                                   plan_a = 1'b0;
    logic                                   plan_b = 1'b0;

    // predictor state
    logic [qdsm_pkg::CFG_DATA_BITS-1:0]     cfg_interval = qdsm_pkg::INTERVAL_RESET;
    logic [qdsm_pkg::CFG_DATA_BITS-1:0]     cfg_round = qdsm_pkg::ROUND_RESET;
    logic                                   enc_a = 1'b0;
    logic                                   enc_b = 1'b0;
    logic signed [qdsm_pkg::STEPS_BITS-1:0] step_total = '0;
    logic [15:0]                            ticks_seen = '0;

    quadrature_decoder_speed_meter i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .level_a          (level_a),
        .level_b          (level_b),
        .ms_tick          (ms_tick),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .window_steps     (window_steps),
        .steps_per_second (steps_per_second),
        .revs_per_minute  (revs_per_minute),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void bump_steps(input logic up);
        if (up)
        begin
            if (step_total != 16'sh7fff)
                step_total = step_total + 16'sd1;
        end
        else if (step_total != 16'sh8000)
            step_total = step_total - 16'sd1;
    endfunction

    task automatic track_sample(input logic a, input logic b, input logic tick);
        speed_word_t speed;
        longint      window;
        longint      per_round;
        longint      sps;
        longint      rpm;
        if (a != enc_a)
        begin
            bump_steps(enc_b != enc_a);
            enc_a = a;
        end
        if (b != enc_b)
        begin
            enc_b = b;
            bump_steps(enc_b != enc_a);
        end
        if (!tick)
            return;
        window = (cfg_interval == 0) ? 1 : longint'(cfg_interval);
        ticks_seen = ticks_seen + 16'd1;
        if (longint'(ticks_seen) < window)
            return;
        ticks_seen = '0;
        per_round = (cfg_round == 0) ? 1 : longint'(cfg_round);
        sps = longint'(step_total) * 1000 / window;
        rpm = sps * 60 / per_round;
        speed.steps = step_total;
        speed.sps = sps[qdsm_pkg::SPS_BITS-1:0];
        speed.rpm = rpm[qdsm_pkg::RPM_BITS-1:0];
        step_total = '0;
        expected_speeds.push_back(speed);
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic push_sample(input logic a, input logic b, input logic tick);
        enc_action_t act;
        act.kind = ACT_SAMPLE;
        act.a = a;
        act.b = b;
        act.tick = tick;
        act.index = '0;
        act.data = '0;
        pending_actions.push_back(act);
        plan_a = a;
        plan_b = b;
    endtask

    task automatic push_drain();
        enc_action_t act;
        act.kind = ACT_DRAIN;
        act.a = 1'b0;
        act.b = 1'b0;
        act.tick = 1'b0;
        act.index = '0;
        act.data = '0;
        pending_actions.push_back(act);
    endtask

    task automatic push_write(input logic [qdsm_pkg::CFG_INDEX_BITS-1:0] index,
                              input logic [qdsm_pkg::CFG_DATA_BITS-1:0] data);
        enc_action_t act;
        push_drain();
        act.kind = ACT_WRITE;
        act.a = 1'b0;
        act.b = 1'b0;
        act.tick = 1'b0;
        act.index = index;
        act.data = data;
        pending_actions.push_back(act);
    endtask

    // one quadrature step forward or backward
    task automatic push_turn(input logic up, input logic tick);
        logic [1:0] phase;
        phase = {plan_a, plan_a ^ plan_b};
        phase = up ? phase + 2'd1 : phase - 2'd1;
        push_sample(phase[1], phase[1] ^ phase[0], tick);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        int          gap_left;
        int          settle_left;
        logic        send_next;
        logic        write_next;
        enc_action_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            quiet <= 1'b0;
            gap_left = 0;
            settle_left = 0;
        end
        else
        begin
            send_next = in_valid && in_stall;
            write_next = cfg_valid && !cfg_ready;
            if (!send_next && !write_next)
            begin
                if (settle_left > 0)
                    settle_left--;
                else if (pending_actions.size() != 0)
                begin
                    head = pending_actions[0];
                    case (head.kind)
                        ACT_SAMPLE:
                        begin
                            if (gap_left > 0)
                                gap_left--;
                            else if (!quiet && $urandom_range(0, 7) == 0)
                                gap_left = $urandom_range(0, 5);
                            else
                            begin
                                send_next = 1'b1;
                                level_a <= head.a;
                                level_b <= head.b;
                                ms_tick <= head.tick;
                                void'(pending_actions.pop_front());
                            end
                        end
                        ACT_WRITE:
                        begin
                            write_next = 1'b1;
                            cfg_index <= head.index;
                            cfg_data <= head.data;
                            void'(pending_actions.pop_front());
                        end
                        ACT_DRAIN:
                        begin
                            if (!in_valid && !cfg_valid && speeds_owed == 0)
                            begin
                                settle_left = SETTLE_CYCLES;
                                void'(pending_actions.pop_front());
                            end
                        end
                        default: ;
                    endcase
                end
            end
            in_valid <= send_next;
            cfg_valid <= write_next;
            quiet <= pending_actions.size() < 40;
        end
    end

    // result side stall bursts
    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        int stall_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        speed_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_speeds.size() == 0)
                    report_mismatch("unexpected result word", 0, window_steps);
                else
                begin
                    want = expected_speeds.pop_front();
                    if (window_steps !== want.steps)
                        report_mismatch("window_steps", want.steps, window_steps);
                    if (steps_per_second !== want.sps)
                        report_mismatch("steps_per_second", want.sps, steps_per_second);
                    if (revs_per_minute !== want.rpm)
                        report_mismatch("revs_per_minute", want.rpm, revs_per_minute);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qdsm_pkg::CFG_INTERVAL: cfg_interval = cfg_data;
                    qdsm_pkg::CFG_ROUND:    cfg_round = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                track_sample(level_a, level_b, ms_tick);
            speeds_owed <= expected_speeds.size();
        end
    end

    // watchdog
    always @(posedge clk)
    begin : watchdog
        int stuck_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic up;
        int   pick;
        // directed: step directions, double changes, register corners
        push_write(qdsm_pkg::CFG_INTERVAL, 16'd1);
        push_write(qdsm_pkg::CFG_ROUND, 16'd4);
        repeat (3) push_turn(1'b1, 1'b0);
        push_turn(1'b1, 1'b1);
        repeat (3) push_turn(1'b0, 1'b0);
        push_turn(1'b0, 1'b1);
        push_sample(1'b0, 1'b1, 1'b0);
        push_sample(1'b1, 1'b0, 1'b0);
        push_sample(1'b0, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_write(qdsm_pkg::CFG_INTERVAL, 16'd0);
        push_write(qdsm_pkg::CFG_ROUND, 16'd0);
        push_sample(1'b1, 1'b1, 1'b1);
        push_write(qdsm_pkg::CFG_ROUND, 16'd3);
        push_sample(1'b0, 1'b1, 1'b1);
        push_write(qdsm_pkg::CFG_INTERVAL, 16'hffff);
        push_write(qdsm_pkg::CFG_ROUND, 16'hffff);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b0);
        push_write(qdsm_pkg::CFG_INTERVAL, 16'd2);
        push_sample(1'b0, 1'b1, 1'b1);
        push_write(qdsm_pkg::CFG_ROUND, 16'd2);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);

        // runs of double changes in both directions
        push_write(qdsm_pkg::CFG_INTERVAL, 16'd1);
        push_write(qdsm_pkg::CFG_ROUND, 16'd1);
        for (int i = 0; i < SATURATE_WORDS; i++)
            push_sample(i[0], !i[0], 1'b0);
        push_sample(plan_a, plan_b, 1'b1);
        push_write(qdsm_pkg::CFG_ROUND, 16'd4);
        for (int i = 0; i < SATURATE_WORDS; i++)
            push_sample(i[0], i[0], 1'b0);
        push_sample(plan_a, plan_b, 1'b1);

        // random rotation with occasional glitches
        up = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       push_write(qdsm_pkg::CFG_INTERVAL, 16'd0);
                1:       push_write(qdsm_pkg::CFG_INTERVAL, 16'($urandom_range(9, 40)));
                default: push_write(qdsm_pkg::CFG_INTERVAL, 16'($urandom_range(1, 6)));
            endcase
            case ($urandom_range(0, 5))
                0:       push_write(qdsm_pkg::CFG_ROUND, 16'($urandom_range(0, 3)));
                1:       push_write(qdsm_pkg::CFG_ROUND, 16'hffff);
                2:       push_write(qdsm_pkg::CFG_ROUND, 16'($urandom_range(4, 65535)));
                default: push_write(qdsm_pkg::CFG_ROUND, 16'($urandom_range(4, 400)));
            endcase
            for (int n = 0; n < 50; n++)
            begin
                if (n == 27 && ph % 3 == 0)
                    push_drain();
                if ($urandom_range(0, 9) == 0)
                    up = !up;
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    push_turn(up, $urandom_range(0, 2) == 0);
                else if (pick < 86)
                    push_sample(plan_a, plan_b, $urandom_range(0, 2) == 0);
                else
                    push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 2) == 0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_actions.size() != 0 || in_valid || cfg_valid
               || expected_speeds.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
